// ===== rtl/core/stack_machine_execute_unit_macros.svh =====
// Assertion helpers for the execute unit RTL.
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define SMX_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define SMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/smx_pkg.sv =====
`timescale 1ns / 1ps
package smx_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int VAR_COUNT   = 256;
    localparam int PC_WIDTH    = 32;
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int VAR_W = $clog2(VAR_COUNT);

    localparam logic [3:0] MODE_MASK      = 4'hf;
    localparam logic [3:0] MODE_IMMEDIATE = 4'h1;

    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_TRAP  = 4'd1;
    localparam logic [3:0] OP_HALT  = 4'd2;
    localparam logic [3:0] OP_EMIT  = 4'd3;
    localparam logic [3:0] OP_READ  = 4'd4;
    localparam logic [3:0] OP_PUSH  = 4'd5;
    localparam logic [3:0] OP_POP   = 4'd6;
    localparam logic [3:0] OP_ADD   = 4'd7;
    localparam logic [3:0] OP_SUB   = 4'd8;
    localparam logic [3:0] OP_MUL   = 4'd9;
    localparam logic [3:0] OP_DIV   = 4'd10;
    localparam logic [3:0] OP_JMP   = 4'd11;
    localparam logic [3:0] OP_JZ    = 4'd12;
    localparam logic [3:0] OP_JP    = 4'd13;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_LINE    = 3'd1;
    localparam logic [2:0] ERR_UNDEF   = 3'd2;
    localparam logic [2:0] ERR_DIVZERO = 3'd3;
    localparam logic [2:0] ERR_UNDER   = 3'd4;
    localparam logic [2:0] ERR_OVER    = 3'd5;
    localparam logic [2:0] ERR_ILLEGAL = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  opcode;
        logic [3:0]  mode;
        logic signed [63:0] operand;
        logic signed [63:0] input_value;
    } smx_in_t;

    typedef struct packed {
        logic [PC_WIDTH-1:0] next_pc;
        logic                print_valid;
        logic signed [63:0]  print_value;
        logic                input_used;
        logic                halted;
        logic [2:0]          error_code;
    } smx_out_t;
endpackage

// ===== rtl/core/smx_in_if.sv =====
`timescale 1ns / 1ps
interface smx_in_if import smx_pkg::*; ();
    logic    valid;
    logic    ready;
    smx_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/smx_out_if.sv =====
`timescale 1ns / 1ps
interface smx_out_if import smx_pkg::*; ();
    logic     valid;
    logic     ready;
    smx_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/smx_ram.sv =====
`timescale 1ns / 1ps
module smx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/smx_div.sv =====
`timescale 1ns / 1ps
module smx_div import smx_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    // Restoring divider on magnitudes, one quotient bit per cycle.
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] diff;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[63]};
        diff  = trial - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[63] ? (~dividend + 64'd1) : dividend;
            den_next  = divisor[63] ? (~divisor + 64'd1) : divisor;
            neg_next  = dividend[63] ^ divisor[63];
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_next = diff[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 64'd1) : quo_reg;
endmodule

// ===== rtl/core/stack_machine_execute_unit.sv =====
`timescale 1ns / 1ps
// Executes one stack machine command per input item and returns one result
// item for it. The operand stack and the variable store live in synchronous
// RAMs with a registered read port; an instruction reads its operands in the
// states RD1 and RD2 and acts in EXEC, which registers the result item. Add,
// sub, multiply and divide without a fault register it in DONE instead, with
// the write back over the second entry: add and sub go there directly, multiply
// through MUL (low partial product) and MUL2 (cross products), and divide
// through DIV, which waits for the bit-serial divider. The defined bits of the
// variable store sit in flip-flops, and a clear command drops them all at once.
// Items are taken one at a time: the next item is accepted only in the idle
// state once the result register is free.
module stack_machine_execute_unit import smx_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    smx_in_if.sink   in_ch,
    smx_out_if.source out_ch
);
`include "stack_machine_execute_unit_macros.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD1   = 3'd1;
    localparam logic [2:0] S_RD2   = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;
    localparam logic [2:0] S_MUL2  = 3'd7;

    logic [2:0]          state_reg, state_next;
    smx_in_t             item_reg, item_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PC_WIDTH-1:0] pc_reg, pc_next;
    logic                stop_reg, stop_next;
    logic [VAR_COUNT-1:0] def_reg, def_next;
    logic [63:0]         top_reg, top_next;
    logic [63:0]         res_reg, res_next;
    logic                oval_reg, oval_next;
    smx_out_t            out_reg, out_next;

    logic                stk_we;
    logic [SP_W-1:0]     stk_waddr, stk_raddr;
    logic [63:0]         stk_wdata, stk_rdata;
    logic                var_we;
    logic [VAR_W-1:0]    var_waddr, var_raddr;
    logic [63:0]         var_rdata;
    logic                div_start, div_done;
    logic [63:0]         div_q;
    logic [63:0]         mul_a_reg, mul_b_reg;
    logic [63:0]         mul_lo;
    logic [31:0]         mul_cross;
    logic                var_in_range;
    logic                is_imm;
    logic [2:0]          err;
    logic [63:0]         sec;

    smx_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );
    smx_ram #(.WIDTH(64), .DEPTH(VAR_COUNT)) u_vars (
        .clk(clk), .we(var_we), .waddr(var_waddr), .wdata(stk_wdata),
        .raddr(var_raddr), .rdata(var_rdata)
    );
    smx_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sec),
        .divisor(top_reg), .done(div_done), .quotient(div_q)
    );

    assign in_ch.ready  = (state_reg == S_IDLE) && !oval_reg;
    assign out_ch.valid = oval_reg;
    assign out_ch.data  = out_reg;

    assign var_in_range = (item_reg.operand[63:VAR_W] == '0);
    assign is_imm       = ((item_reg.mode & MODE_MASK) == MODE_IMMEDIATE);
    assign sec          = stk_rdata;

    // Low 64 bits of the product: the low partial product first, then the
    // cross products, of which only the low halves reach the result.
    assign mul_lo    = 64'(mul_a_reg[31:0]) * 64'(mul_b_reg[31:0]);
    assign mul_cross = mul_a_reg[31:0] * mul_b_reg[63:32]
                     + mul_a_reg[63:32] * mul_b_reg[31:0];

    // Stack read address: top entry first, second entry in the last read cycle.
    always_comb
    begin
        stk_raddr = SP_W'(cnt_reg - CNT_W'(1));
        if (state_reg == S_RD2)
        begin
            stk_raddr = SP_W'(cnt_reg - CNT_W'(2));
        end
        var_raddr = item_reg.operand[VAR_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        cnt_next   = cnt_reg;
        pc_next    = pc_reg;
        stop_next  = stop_reg;
        def_next   = def_reg;
        top_next   = top_reg;
        res_next   = res_reg;
        oval_next  = oval_reg;
        out_next   = out_reg;
        stk_we     = 1'b0;
        stk_waddr  = SP_W'(cnt_reg);
        stk_wdata  = '0;
        var_we     = 1'b0;
        var_waddr  = item_reg.operand[VAR_W-1:0];
        div_start  = 1'b0;
        err        = ERR_NONE;
        if (out_ch.ready && oval_reg)
        begin
            oval_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && !oval_reg)
                begin
                    item_next  = in_ch.data;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                // Top entry arrives next cycle.
                state_next = S_RD2;
            end
            S_RD2:
            begin
                top_next   = stk_rdata;
                state_next = S_EXEC;
            end
            S_MUL:
            begin
                res_next   = mul_lo;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                res_next   = res_reg + {mul_cross, 32'd0};
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_q;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Write back the arithmetic result over the second entry.
                stk_we    = 1'b1;
                stk_waddr = SP_W'(cnt_reg - CNT_W'(2));
                stk_wdata = res_reg;
                cnt_next  = cnt_reg - CNT_W'(1);
                out_next  = '{next_pc: pc_reg, print_valid: 1'b0,
                              print_value: '0, input_used: 1'b0,
                              halted: stop_reg, error_code: ERR_NONE};
                oval_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_EXEC:
            begin
                out_next = '{next_pc: pc_reg, print_valid: 1'b0,
                             print_value: '0, input_used: 1'b0,
                             halted: stop_reg, error_code: ERR_NONE};
                state_next = S_IDLE;
                oval_next  = 1'b1;
                case (item_reg.command)
                    CMD_START:
                    begin
                        pc_next   = '0;
                        stop_next = 1'b0;
                    end
                    CMD_CLEAR:
                    begin
                        pc_next   = '0;
                        stop_next = 1'b0;
                        cnt_next  = '0;
                        def_next  = '0;
                    end
                    CMD_EXEC:
                    begin
                        if (!stop_reg)
                        begin
                            pc_next = pc_reg + PC_WIDTH'(1);
                            case (item_reg.opcode)
                                OP_NOP: ;
                                OP_TRAP: err = ERR_LINE;
                                OP_HALT: stop_next = 1'b1;
                                OP_EMIT:
                                begin
                                    if (cnt_reg < CNT_W'(1)) err = ERR_UNDER;
                                    else
                                    begin
                                        out_next.print_valid = 1'b1;
                                        out_next.print_value = top_reg;
                                        cnt_next = cnt_reg - CNT_W'(1);
                                    end
                                end
                                OP_READ:
                                begin
                                    if (cnt_reg >= CNT_W'(STACK_DEPTH)) err = ERR_OVER;
                                    else
                                    begin
                                        stk_we    = 1'b1;
                                        stk_wdata = item_reg.input_value;
                                        cnt_next  = cnt_reg + CNT_W'(1);
                                        out_next.input_used = 1'b1;
                                    end
                                end
                                OP_PUSH:
                                begin
                                    if (!is_imm && (!var_in_range ||
                                        !def_reg[item_reg.operand[VAR_W-1:0]]))
                                    begin
                                        err = ERR_UNDEF;
                                    end
                                    else if (cnt_reg >= CNT_W'(STACK_DEPTH))
                                    begin
                                        err = ERR_OVER;
                                    end
                                    else
                                    begin
                                        stk_we    = 1'b1;
                                        stk_wdata = is_imm ? item_reg.operand : var_rdata;
                                        cnt_next  = cnt_reg + CNT_W'(1);
                                    end
                                end
                                OP_POP:
                                begin
                                    if (cnt_reg < CNT_W'(1)) err = ERR_UNDER;
                                    else
                                    begin
                                        if (var_in_range)
                                        begin
                                            var_we    = 1'b1;
                                            stk_wdata = top_reg;
                                            def_next[item_reg.operand[VAR_W-1:0]] = 1'b1;
                                        end
                                        cnt_next = cnt_reg - CNT_W'(1);
                                    end
                                end
                                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                                begin
                                    // Second entry is on the RAM output now.
                                    if (cnt_reg < CNT_W'(2)) err = ERR_UNDER;
                                    else if (item_reg.opcode == OP_DIV && top_reg == '0)
                                    begin
                                        err = ERR_DIVZERO;
                                    end
                                    else
                                    begin
                                        oval_next = oval_reg && !out_ch.ready;
                                        if (item_reg.opcode == OP_ADD)
                                        begin
                                            res_next   = sec + top_reg;
                                            state_next = S_DONE;
                                        end
                                        else if (item_reg.opcode == OP_SUB)
                                        begin
                                            res_next   = sec - top_reg;
                                            state_next = S_DONE;
                                        end
                                        else if (item_reg.opcode == OP_MUL)
                                        begin
                                            state_next = S_MUL;
                                        end
                                        else
                                        begin
                                            div_start  = 1'b1;
                                            state_next = S_DIV;
                                        end
                                    end
                                end
                                OP_JMP: pc_next = item_reg.operand[PC_WIDTH-1:0];
                                OP_JZ, OP_JP:
                                begin
                                    if (cnt_reg < CNT_W'(1)) err = ERR_UNDER;
                                    else
                                    begin
                                        cnt_next = cnt_reg - CNT_W'(1);
                                        if ((item_reg.opcode == OP_JZ && top_reg == '0) ||
                                            (item_reg.opcode == OP_JP && top_reg != '0 &&
                                             !top_reg[63]))
                                        begin
                                            pc_next = item_reg.operand[PC_WIDTH-1:0];
                                        end
                                    end
                                end
                                default: err = ERR_ILLEGAL;
                            endcase
                            if (err != ERR_NONE)
                            begin
                                // Fault: keep stack and variables, stop.
                                stk_we    = 1'b0;
                                var_we    = 1'b0;
                                cnt_next  = cnt_reg;
                                def_next  = def_reg;
                                stop_next = 1'b1;
                                out_next.print_valid = 1'b0;
                                out_next.print_value = '0;
                                out_next.input_used  = 1'b0;
                            end
                            out_next.next_pc    = pc_next;
                            out_next.halted     = stop_next;
                            out_next.error_code = err;
                        end
                    end
                    default: ;
                endcase
                if (item_reg.command != CMD_EXEC)
                begin
                    out_next.next_pc = pc_next;
                    out_next.halted  = stop_next;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pc_reg    <= '0;
            stop_reg  <= 1'b0;
            def_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pc_reg    <= pc_next;
            stop_reg  <= stop_next;
            def_reg   <= def_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        top_reg  <= top_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        if (state_reg == S_EXEC)
        begin
            mul_a_reg <= sec;
            mul_b_reg <= top_reg;
        end
    end

    `SMX_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(STACK_DEPTH),
        "stack count beyond depth")
    `SMX_ASSERT_IMPL(a_accept_idle, clk, rst_n, in_ch.valid && in_ch.ready,
        state_reg == S_IDLE && !oval_reg, "item accepted while busy")
    `SMX_ASSERT_NEXT(a_err_halts, clk, rst_n,
        state_reg == S_EXEC && err != ERR_NONE, stop_reg,
        "fault did not stop the machine")
    `SMX_ASSERT_IMPL(a_no_dual_write, clk, rst_n, var_we, !stk_we,
        "stack and variable written together")
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import smx_pkg::*;

    logic clk;
    logic rst_n;

    smx_in_if  in_ch ();
    smx_out_if out_ch ();

    stack_machine_execute_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Mirror of the machine state, kept in step with accepted items.
    logic [63:0]         mdl_stack [STACK_DEPTH];
    int unsigned         mdl_depth;
    logic [63:0]         mdl_vars [VAR_COUNT];
    bit                  mdl_defined [VAR_COUNT];
    logic [PC_WIDTH-1:0] mdl_pc;
    bit                  mdl_stopped;

    smx_out_t expected_q [$];
    int       mismatches;
    bit       sink_hold;     // long receiver hold-off
    bit       sink_calm;     // no random stalls near the end
    bit       drain_done;

    // Directed rows: the item and, where obvious, the result typed in.
    typedef struct {
        smx_in_t  item;
        bit       typed;
        smx_out_t result;
    } stim_row_t;
    stim_row_t directed_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void clear_machine();
        mdl_depth   = 0;
        mdl_pc      = '0;
        mdl_stopped = 1'b0;
        foreach (mdl_defined[i]) mdl_defined[i] = 1'b0;
    endfunction

    function automatic logic [63:0] quotient_toward_zero(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    // Advance the mirrored machine by one item and return its result.
    function automatic smx_out_t machine_step(smx_in_t it);
        smx_out_t    r;
        logic [2:0]  err;
        logic [63:0] a;
        logic [63:0] b;
        int unsigned sc;
        r   = '0;
        err = ERR_NONE;
        sc  = mdl_depth;
        if (it.command == CMD_EXEC && !mdl_stopped)
        begin
            mdl_pc = mdl_pc + 1'b1;
            case (it.opcode)
                OP_NOP: ;
                OP_TRAP: err = ERR_LINE;
                OP_HALT: mdl_stopped = 1'b1;
                OP_EMIT:
                    if (sc < 1) err = ERR_UNDER;
                    else
                    begin
                        r.print_value = mdl_stack[sc-1];
                        r.print_valid = 1'b1;
                        mdl_depth     = sc - 1;
                    end
                OP_READ:
                    if (sc >= STACK_DEPTH) err = ERR_OVER;
                    else
                    begin
                        mdl_stack[sc] = it.input_value;
                        mdl_depth     = sc + 1;
                        r.input_used  = 1'b1;
                    end
                OP_PUSH:
                begin
                    if ((it.mode & MODE_MASK) == MODE_IMMEDIATE)
                        a = it.operand;
                    else if (it.operand >= 64'(VAR_COUNT) || it.operand < 0
                             || !mdl_defined[it.operand[VAR_W-1:0]])
                        err = ERR_UNDEF;
                    else
                        a = mdl_vars[it.operand[VAR_W-1:0]];
                    if (err == ERR_NONE)
                    begin
                        if (sc >= STACK_DEPTH) err = ERR_OVER;
                        else
                        begin
                            mdl_stack[sc] = a;
                            mdl_depth     = sc + 1;
                        end
                    end
                end
                OP_POP:
                    if (sc < 1) err = ERR_UNDER;
                    else
                    begin
                        if (it.operand >= 0 && it.operand < 64'(VAR_COUNT))
                        begin
                            mdl_vars[it.operand[VAR_W-1:0]]    = mdl_stack[sc-1];
                            mdl_defined[it.operand[VAR_W-1:0]] = 1'b1;
                        end
                        mdl_depth = sc - 1;
                    end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    if (sc < 2) err = ERR_UNDER;
                    else
                    begin
                        b = mdl_stack[sc-1];
                        a = mdl_stack[sc-2];
                        case (it.opcode)
                            OP_ADD: a = a + b;
                            OP_SUB: a = a - b;
                            OP_MUL: a = a * b;
                            default:
                                if (b == 0) err = ERR_DIVZERO;
                                else a = quotient_toward_zero(a, b);
                        endcase
                        if (err == ERR_NONE)
                        begin
                            mdl_stack[sc-2] = a;
                            mdl_depth       = sc - 1;
                        end
                    end
                OP_JMP: mdl_pc = it.operand[PC_WIDTH-1:0];
                OP_JZ, OP_JP:
                    if (sc < 1) err = ERR_UNDER;
                    else
                    begin
                        a         = mdl_stack[sc-1];
                        mdl_depth = sc - 1;
                        if ((it.opcode == OP_JZ && a == 0) ||
                            (it.opcode == OP_JP && a != 0 && !a[63]))
                            mdl_pc = it.operand[PC_WIDTH-1:0];
                    end
                default: err = ERR_ILLEGAL;
            endcase
            if (err != ERR_NONE)
            begin
                mdl_stopped = 1'b1;
                r = '0;
            end
        end
        else if (it.command == CMD_START)
        begin
            mdl_pc      = '0;
            mdl_stopped = 1'b0;
        end
        else if (it.command == CMD_CLEAR)
            clear_machine();
        r.next_pc    = mdl_pc;
        r.halted     = mdl_stopped;
        r.error_code = err;
        return r;
    endfunction

    function automatic smx_in_t make_item(logic [1:0] cmd, logic [3:0] op,
                                          logic [3:0] md, logic [63:0] opnd,
                                          logic [63:0] inval);
        smx_in_t it;
        it.command     = cmd;
        it.opcode      = op;
        it.mode        = md;
        it.operand     = opnd;
        it.input_value = inval;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7fff_ffff_ffff_ffff;
            2: v = 64'($urandom_range(0, 3)) - 64'd1;
            3: v = {$urandom, $urandom};
            default: v = $signed(64'($urandom_range(0, 40))) - 64'sd20;
        endcase
        return v;
    endfunction

    // Mostly well-formed code on the live machine, with some noise.
    function automatic smx_in_t random_item();
        int unsigned pick;
        logic [3:0]  op;
        logic [3:0]  md;
        logic [63:0] opnd;
        pick = $urandom_range(0, 99);
        md   = 4'($urandom_range(0, 15));
        opnd = 64'($urandom_range(0, 15));
        if (pick < 4)
            return make_item(CMD_START, 4'($urandom), 4'($urandom), rand64(), rand64());
        if (pick < 5)
            return make_item(CMD_CLEAR, 4'($urandom), 4'($urandom), rand64(), rand64());
        if (pick < 6)
            return make_item(CMD_NONE, 4'($urandom), 4'($urandom), rand64(), rand64());
        if (mdl_stopped && $urandom_range(0, 3) != 0)
            return make_item(CMD_START, 4'($urandom), 4'($urandom), rand64(), rand64());
        if (pick < 12)
            return make_item(CMD_EXEC, 4'($urandom), md, rand64(), rand64());
        // keep the stack near a few entries, now and then run it full
        if (mdl_depth < 2 || ($urandom_range(0, 3) == 0 && mdl_depth < STACK_DEPTH))
        begin
            op = ($urandom_range(0, 2) == 0) ? OP_READ : OP_PUSH;
            if (op == OP_PUSH && $urandom_range(0, 2) != 0)
            begin
                md   = MODE_IMMEDIATE;
                opnd = rand64();
            end
            else if (op == OP_PUSH && $urandom_range(0, 7) == 0)
                opnd = ($urandom_range(0, 1) != 0) ? rand64() : 64'(VAR_COUNT - 1);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: op = OP_EMIT;
                1: op = OP_POP;
                2: op = OP_ADD;
                3: op = OP_SUB;
                4: op = OP_MUL;
                5: op = OP_DIV;
                6: op = OP_JZ;
                7: op = OP_JP;
                8: op = OP_JMP;
                default: op = OP_NOP;
            endcase
            if (op == OP_JMP || op == OP_JZ || op == OP_JP || $urandom_range(0, 9) == 0)
                opnd = rand64();
        end
        return make_item(CMD_EXEC, op, md, opnd, rand64());
    endfunction

    function automatic void add_row(smx_in_t it);
        stim_row_t row;
        row.item  = it;
        row.typed = 1'b0;
        row.result = '0;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_typed(smx_in_t it, logic [31:0] pc, bit halt,
                                      logic [2:0] err);
        stim_row_t row;
        row.item   = it;
        row.typed  = 1'b1;
        row.result = '0;
        row.result.next_pc    = pc;
        row.result.halted     = halt;
        row.result.error_code = err;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Predict and queue the result of an item at acceptance.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_q.insert(expected_q.size(), machine_step(in_ch.data));
    end

    // Compare each result item with the oldest prediction.
    always @(posedge clk)
    begin
        smx_out_t want;
        smx_out_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_q.size() == 0)
                report_mismatch("unexpected item", 64'(got.next_pc), 64'd0);
            else
            begin
                want = expected_q.pop_front();
                if (got.next_pc !== want.next_pc)
                    report_mismatch("next_pc", 64'(got.next_pc), 64'(want.next_pc));
                if (got.print_valid !== want.print_valid)
                    report_mismatch("print_valid", 64'(got.print_valid),
                                    64'(want.print_valid));
                if (got.print_value !== want.print_value)
                    report_mismatch("print_value", got.print_value, want.print_value);
                if (got.input_used !== want.input_used)
                    report_mismatch("input_used", 64'(got.input_used),
                                    64'(want.input_used));
                if (got.halted !== want.halted)
                    report_mismatch("halted", 64'(got.halted), 64'(want.halted));
                if (got.error_code !== want.error_code)
                    report_mismatch("error_code", 64'(got.error_code),
                                    64'(want.error_code));
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off, calm at the end.
    initial
    begin
        int burst;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold)
                out_ch.ready <= 1'b0;
            else if (!sink_calm && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 16);
                out_ch.ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Hold valid until the item is taken; sample ready at the rising edge.
    task automatic send_item(smx_in_t it, bit gaps);
        int burst;
        if (gaps && $urandom_range(0, 5) == 0)
        begin
            burst = $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            repeat (burst) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(negedge clk);
    endtask

    // Sender: directed table, then random code with pauses and pressure.
    initial
    begin
        smx_in_t it;
        mismatches   = 0;
        sink_hold    = 1'b0;
        sink_calm    = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        clear_machine();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes, every opcode except HALT and JP, and the listed corner cases.
        add_typed(make_item(CMD_EXEC, OP_NOP, 4'd0, 64'd0, 64'd0), 32'd1, 1'b0, ERR_NONE);
        add_typed(make_item(CMD_EXEC, OP_EMIT, 4'd0, 64'd0, 64'd0), 32'd2, 1'b1, ERR_UNDER);
        add_typed(make_item(CMD_EXEC, OP_NOP, 4'd0, 64'd0, 64'd0), 32'd2, 1'b1, ERR_NONE);
        add_typed(make_item(CMD_START, 4'hf, 4'hf, '1, '1), 32'd0, 1'b0, ERR_NONE);
        add_row(make_item(CMD_EXEC, OP_READ, 4'd0, 64'd0, 64'h8000_0000_0000_0000));
        add_row(make_item(CMD_EXEC, OP_PUSH, MODE_IMMEDIATE, '1, 64'd0));
        add_row(make_item(CMD_EXEC, OP_DIV, 4'd0, 64'd0, 64'd0));
        add_row(make_item(CMD_EXEC, OP_POP, 4'd0, 64'(VAR_COUNT - 1), 64'd0));
        add_row(make_item(CMD_EXEC, OP_PUSH, 4'd0, 64'(VAR_COUNT - 1), 64'd0));
        add_row(make_item(CMD_EXEC, OP_PUSH, MODE_IMMEDIATE, 64'h7fff_ffff_ffff_ffff, 64'd0));
        add_row(make_item(CMD_EXEC, OP_MUL, 4'd0, 64'd0, 64'd0));
        add_row(make_item(CMD_EXEC, OP_PUSH, 4'hf, 64'd9, 64'd0));
        add_typed(make_item(CMD_START, 4'd0, 4'd0, 64'd0, 64'd0), 32'd0, 1'b0, ERR_NONE);
        add_row(make_item(CMD_EXEC, OP_POP, 4'd0, 64'h8000_0000_0000_0000, 64'd0));
        add_row(make_item(CMD_EXEC, OP_PUSH, MODE_IMMEDIATE, 64'd0, 64'd0));
        add_row(make_item(CMD_EXEC, OP_DIV, 4'd0, 64'd0, 64'd0));
        add_row(make_item(CMD_START, 4'd0, 4'd0, 64'd0, 64'd0));
        add_row(make_item(CMD_EXEC, OP_JZ, 4'd0, 64'hffff_ffff_1234_5678, 64'd0));
        add_row(make_item(CMD_EXEC, OP_SUB, 4'd0, 64'd0, 64'd0));
        add_row(make_item(CMD_START, 4'd0, 4'd0, 64'd0, 64'd0));
        add_row(make_item(CMD_EXEC, OP_JMP, 4'd0, 64'h0000_0001_ffff_ffff, 64'd0));
        add_row(make_item(CMD_EXEC, OP_ADD, 4'd0, 64'd0, 64'd0));
        add_row(make_item(CMD_EXEC, OP_TRAP, 4'd0, 64'd0, 64'd0));
        add_row(make_item(CMD_NONE, 4'd0, 4'd0, 64'd0, 64'd0));
        add_typed(make_item(CMD_CLEAR, 4'd0, 4'd0, 64'd0, 64'd0), 32'd0, 1'b0, ERR_NONE);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].item, 1'b0);
            if (directed_rows[i].typed)
            begin
                wait_drained();
                @(posedge clk);
            end
        end
        // typed rows: check the predictor itself agrees with the table
        begin
            smx_out_t chk;
            clear_machine();
            foreach (directed_rows[i])
            begin
                chk = machine_step(directed_rows[i].item);
                if (directed_rows[i].typed && chk != directed_rows[i].result)
                    report_mismatch("table row", 64'(i), 64'(chk.error_code));
            end
            clear_machine();
        end
        // resync the predictor state: table ended with a clear anyway
        wait_drained();

        // Random code, with a long receiver hold-off early on.
        for (int n = 0; n < 800; n++)
        begin
            if (n == 100)
            begin
                sink_hold = 1'b1;
                fork
                    begin
                        repeat (300) @(negedge clk);
                        sink_hold = 1'b0;
                    end
                join_none
            end
            if (n == 400)
                wait_drained();
            if (n == 700)
                sink_calm = 1'b1;
            it = random_item();
            send_item(it, n < 700);
        end
        in_ch.valid <= 1'b0;

        fork
            begin
                wait_drained();
                repeat (100) @(negedge clk);
                drain_done = 1'b1;
            end
            begin
                repeat (200000) @(negedge clk);
            end
        join_any
        if (!drain_done)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            if (mismatches == 0 && expected_q.size() == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
            $finish;
        end
    end

endmodule

// ===== stack_machine_execute_unit.f =====
+incdir+rtl/core
rtl/core/smx_pkg.sv
rtl/core/smx_in_if.sv
rtl/core/smx_out_if.sv
rtl/core/smx_ram.sv
rtl/core/smx_div.sv
rtl/core/stack_machine_execute_unit.sv
bench/tb_top.sv
